@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL files; the top-level file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk while rst_n is high.
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/fvn_pkg.sv @@
// Shared types and constants of the fractal value noise color blender.
package fvn_pkg;

  localparam int COORD_RANGE = 256;
  localparam int PIX_W       = 8;
  localparam int COLOR_W     = 24;
  localparam int CHANNELS    = 3;
  localparam int CORNERS     = 4;
  localparam int FULL_WEIGHT = 255;
  localparam int SUM_W       = PIX_W + 1;
  localparam int MIX_W       = 2 * PIX_W;
  localparam int CFG_IDX_W   = 1;

  // Exact divide by 255 for dividends below 2^16: (n * ceil(2^24 / 255)) >> 24.
  localparam int                     BLEND_SHIFT = 24;
  localparam int                     BLEND_MUL_W = 17;
  localparam logic [BLEND_MUL_W-1:0] BLEND_RECIP = 17'd65794;

  localparam logic [COLOR_W-1:0] COLOR_HIGH_RST = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] COLOR_LOW_RST  = 24'h000000;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_HIGH = 1'b0,
    CFG_COLOR_LOW  = 1'b1
  } cfg_reg_t;

  // Stage-one item as seen by every octave lane.
  typedef struct packed {
    logic             adv;
    logic             rd_en;
    logic             wr_en;
    logic [PIX_W-1:0] x_coord;
    logic [PIX_W-1:0] y_coord;
    logic [PIX_W-1:0] wr_idx;
    logic [PIX_W-1:0] wr_data;
  } fvn_lane_in_t;

endpackage

@@ hw/rtl/fvn_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface fvn_in_if import fvn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [PIX_W-1:0] x_coord;
  logic [PIX_W-1:0] y_coord;
  logic [PIX_W-1:0] table_index;
  logic [PIX_W-1:0] table_value;

  modport source (
    output valid, cmd, x_coord, y_coord, table_index, table_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, x_coord, y_coord, table_index, table_value,
    output ready
  );
endinterface

interface fvn_out_if import fvn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   intensity;
  logic [COLOR_W-1:0] pixel_color;

  modport source (
    output valid, intensity, pixel_color,
    input  ready
  );
  modport sink (
    input  valid, intensity, pixel_color,
    output ready
  );
endinterface

@@ hw/rtl/fvn_lane.sv @@
// One octave lane: table copies, bilinear interpolation and scaling by the octave.
module fvn_lane import fvn_pkg::*; #(
  parameter int GRID_CELLS = 16,
  parameter int OCT        = 0
) (
  input  logic             clk,
  input  fvn_lane_in_t     ctl,
  output logic [PIX_W-1:0] oct_val_r
);

  localparam int CellSpan   = COORD_RANGE / GRID_CELLS;
  localparam int TableSize  = GRID_CELLS * GRID_CELLS;
  localparam int CW         = $clog2(GRID_CELLS);
  localparam int FW         = $clog2(CellSpan + 1);
  localparam int AW         = $clog2(TableSize);
  localparam int Div        = CellSpan * CellSpan;
  localparam int WW         = $clog2(Div + 1);
  localparam int RW         = $clog2(FULL_WEIGHT * Div + 1);
  localparam int DivLog     = $clog2(Div);
  localparam int RecipShift = RW + DivLog;
  localparam longint unsigned RecipMul =
    ((64'd1 << RecipShift) + 64'(Div) - 64'd1) / 64'(Div);
  localparam int MW         = $clog2(RecipMul + 1);
  localparam int PW         = RW + MW;

  // Cell number and offset within the cell for every coordinate, with the
  // saturation needed when the grid does not divide the coordinate range.
  logic [CW-1:0] cell_lut [COORD_RANGE];
  logic [FW-1:0] frac_lut [COORD_RANGE];

  for (genvar p = 0; p < COORD_RANGE; p++) begin : g_lut
    localparam int CellRaw = p / CellSpan;
    localparam int CellSat = (CellRaw >= GRID_CELLS) ? GRID_CELLS - 1 : CellRaw;
    localparam int FracRaw = p - CellSat * CellSpan;
    localparam int FracSat = (FracRaw > CellSpan) ? CellSpan : FracRaw;
    assign cell_lut[p] = CW'(CellSat);
    assign frac_lut[p] = FW'(FracSat);
  end

  logic [PIX_W-1:0] px, py;
  logic [CW-1:0]    xa, ya, xb, yb;
  logic [FW-1:0]    fx, fy, gx, gy;
  logic [AW-1:0]    rd_addr [CORNERS];
  logic [WW-1:0]    wgt     [CORNERS];
  logic [AW-1:0]    wr_addr;
  logic             wr_hit;

  assign px = ctl.x_coord << OCT;
  assign py = ctl.y_coord << OCT;
  assign xa = cell_lut[px];
  assign ya = cell_lut[py];
  assign fx = frac_lut[px];
  assign fy = frac_lut[py];
  assign xb = (xa == CW'(GRID_CELLS - 1)) ? '0 : xa + 1'b1;
  assign yb = (ya == CW'(GRID_CELLS - 1)) ? '0 : ya + 1'b1;
  assign gx = FW'(CellSpan) - fx;
  assign gy = FW'(CellSpan) - fy;

  assign rd_addr[0] = AW'(int'(xa) * GRID_CELLS + int'(ya));
  assign rd_addr[1] = AW'(int'(xa) * GRID_CELLS + int'(yb));
  assign rd_addr[2] = AW'(int'(xb) * GRID_CELLS + int'(ya));
  assign rd_addr[3] = AW'(int'(xb) * GRID_CELLS + int'(yb));

  assign wgt[0] = WW'(gx) * WW'(gy);
  assign wgt[1] = WW'(gx) * WW'(fy);
  assign wgt[2] = WW'(fx) * WW'(gy);
  assign wgt[3] = WW'(fx) * WW'(fy);

  assign wr_addr = AW'(ctl.wr_idx);
  assign wr_hit  = ctl.wr_en && (int'(ctl.wr_idx) < TableSize);

  // Every corner has its own copy of the table, so all four reads share a cycle.
  logic [PIX_W-1:0] rdata [CORNERS];

  for (genvar c = 0; c < CORNERS; c++) begin : g_corner
    logic [PIX_W-1:0] mem [TableSize];
    logic [PIX_W-1:0] rdata_r;

    always_ff @(posedge clk) begin
      if (wr_hit) begin
        mem[wr_addr] <= ctl.wr_data;
      end
      if (ctl.adv && ctl.rd_en) begin
        rdata_r <= mem[rd_addr[c]];
      end
    end

    assign rdata[c] = rdata_r;
  end

  logic [WW-1:0]    wgt_r [CORNERS];
  logic [RW-1:0]    acc_nxt, acc_r;
  logic [PW-1:0]    prod;
  logic [PIX_W-1:0] oct_val_nxt;

  always_comb begin
    acc_nxt = '0;
    for (int c = 0; c < CORNERS; c++) begin
      acc_nxt = acc_nxt + RW'(wgt_r[c]) * RW'(rdata[c]);
    end
  end

  assign prod        = PW'(acc_r) * PW'(RecipMul);
  assign oct_val_nxt = prod[RecipShift +: PIX_W] >> OCT;

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      wgt_r     <= wgt;
      acc_r     <= acc_nxt;
      oct_val_r <= oct_val_nxt;
    end
  end

endmodule

@@ hw/rtl/fractal_value_noise_color_blend.sv @@
// Top level of the fractal value noise texture with two-color blend.
//
// Input channel in_ch carries one item per transfer. cmd = CMD_LOAD stores
// table_value at table_index in the noise table and gives no result;
// cmd = CMD_PIXEL computes one pixel from x_coord and y_coord and gives one
// result on out_ch (intensity and the blended RGB888 pixel_color).
// Results leave in the order their items were accepted.
// Configuration: cfg_we writes cfg_wdata into color_high (index 0) or
// color_low (index 1) at the clock edge; write only while the block is idle.
// Pipeline: a pixel passes the input register, the lane stages, the octave sum
// and the weighted sums into the output register. Throughput is one item per
// clock without stalls; all OCTAVES lanes work side by side, each with four
// private table copies. A stalled receiver freezes the whole pipeline;
// in_ch.ready then drops, and nothing is lost or repeated. Out of reset,
// in_ch.ready is high whenever the output register is empty or being drained.
// Reset (rst_n low, synchronous) empties the pipeline, holds in_ch.ready low
// and restores both colors. The noise table is not cleared: every entry must
// be loaded before a pixel reads it.
`include "assert_macros.svh"

module fractal_value_noise_color_blend import fvn_pkg::*; #(
  parameter int GRID_CELLS = 16,
  parameter int OCTAVES    = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  fvn_in_if.sink               in_ch,
  fvn_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_wdata
);

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;

  assign adv         = !v7_r || out_ch.ready;
  assign in_ch.ready = rst_n && adv;

  // Configuration registers.
  logic [COLOR_W-1:0] color_high_r, color_low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_high_r <= COLOR_HIGH_RST;
      color_low_r  <= COLOR_LOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_COLOR_HIGH: color_high_r <= cfg_wdata;
        CFG_COLOR_LOW:  color_low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage one: input register.
  logic             cmd1_r;
  logic [PIX_W-1:0] x1_r, y1_r, idx1_r, val1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1_r <= in_ch.cmd;
      x1_r   <= in_ch.x_coord;
      y1_r   <= in_ch.y_coord;
      idx1_r <= in_ch.table_index;
      val1_r <= in_ch.table_value;
    end
  end

  fvn_lane_in_t lane_ctl;

  always_comb begin
    lane_ctl.adv     = adv;
    lane_ctl.rd_en   = v1_r && (cmd1_r == CMD_PIXEL);
    lane_ctl.wr_en   = v1_r && (cmd1_r == CMD_LOAD) && adv;
    lane_ctl.x_coord = x1_r;
    lane_ctl.y_coord = y1_r;
    lane_ctl.wr_idx  = idx1_r;
    lane_ctl.wr_data = val1_r;
  end

  // Stages two to four live in the lanes.
  logic [PIX_W-1:0] oct_val [OCTAVES];

  for (genvar l = 0; l < OCTAVES; l++) begin : g_lane
    fvn_lane #(
      .GRID_CELLS (GRID_CELLS),
      .OCT        (l)
    ) u_lane (
      .clk       (clk),
      .ctl       (lane_ctl),
      .oct_val_r (oct_val[l])
    );
  end

  // Stage five: octave sum, halved. The sum stays below 512.
  logic [SUM_W-1:0] sum_nxt;
  logic [PIX_W-1:0] inten_nxt, inten5_r, inten6_r, inten7_r;

  always_comb begin
    sum_nxt = '0;
    for (int l = 0; l < OCTAVES; l++) begin
      sum_nxt = sum_nxt + SUM_W'(oct_val[l]);
    end
  end

  assign inten_nxt = sum_nxt[SUM_W-1:1];

  // Stage six: per-channel weighted sums.
  logic [MIX_W-1:0] mix_nxt [CHANNELS];
  logic [MIX_W-1:0] mix_r   [CHANNELS];
  logic [PIX_W-1:0] inv_weight;

  assign inv_weight = PIX_W'(FULL_WEIGHT) - inten5_r;

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      mix_nxt[ch] = MIX_W'(color_low_r[ch*PIX_W +: PIX_W]) * MIX_W'(inv_weight)
                  + MIX_W'(color_high_r[ch*PIX_W +: PIX_W]) * MIX_W'(inten5_r);
    end
  end

  // Stage seven: divide by 255 through the reciprocal, into the output register.
  logic [MIX_W+BLEND_MUL_W-1:0] blend_prod [CHANNELS];
  logic [COLOR_W-1:0]           color_nxt, color7_r;

  always_comb begin
    color_nxt = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      blend_prod[ch] = (MIX_W + BLEND_MUL_W)'(mix_r[ch])
                     * (MIX_W + BLEND_MUL_W)'(BLEND_RECIP);
      color_nxt[ch*PIX_W +: PIX_W] = blend_prod[ch][BLEND_SHIFT +: PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inten5_r <= inten_nxt;
      inten6_r <= inten5_r;
      mix_r    <= mix_nxt;
      inten7_r <= inten6_r;
      color7_r <= color_nxt;
    end
  end

  // Valid bits travel with the data; loads leave the pipeline after stage one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
      v2_r <= lane_ctl.rd_en;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  assign out_ch.valid       = v7_r;
  assign out_ch.intensity   = inten7_r;
  assign out_ch.pixel_color = color7_r;

  logic [6:0] vld_vec;
  assign vld_vec = {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r};

  `ASSERT_ALWAYS(a_stall_blocks_input, out_ch.valid && !out_ch.ready |-> !in_ch.ready, "input taken while the output is stalled")
  `ASSERT_CLKD(a_load_no_result, lane_ctl.wr_en |=> !v2_r, "table load entered the pixel pipeline")
  `ASSERT_CLKD(a_stall_holds_valids, !adv |=> $stable(vld_vec), "pipeline moved during a stall")
  `ASSERT_CLKD(a_last_stage_moves, adv && v6_r |=> v7_r, "pixel lost before the output register")

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the fractal value noise color blender.
module tb;
  import fvn_pkg::*;

  localparam int GRID         = 16;
  localparam int SPAN         = COORD_RANGE / GRID;
  localparam int OCT_COUNT    = 8;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 150;

  typedef struct packed {
    logic [PIX_W-1:0]   intensity;
    logic [COLOR_W-1:0] color;
  } pixel_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_COLOR_HIGH;
  logic [COLOR_W-1:0]   cfg_wdata = '0;

  fvn_in_if  in_ch ();
  fvn_out_if out_ch ();

  fractal_value_noise_color_blend #(
    .GRID_CELLS (GRID),
    .OCTAVES    (OCT_COUNT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the block's state, updated at each accepted transfer and color write.
  logic [PIX_W-1:0]   noise_grid [GRID*GRID];
  logic [COLOR_W-1:0] hue_hi = COLOR_HIGH_RST;
  logic [COLOR_W-1:0] hue_lo = COLOR_LOW_RST;
  pixel_res_t         pending_pixels [$];
  pixel_res_t         want;

  int errors = 0;
  int pixels_checked = 0;
  int loads_done = 0;
  int cfg_writes = 0;
  int cycles = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;

  function automatic int unsigned bilerp(input int unsigned px, input int unsigned py);
    int unsigned cx, cy, fx, fy, nx, ny, gx, gy, acc;
    cx = px / SPAN;
    cy = py / SPAN;
    fx = px % SPAN;
    fy = py % SPAN;
    nx = (cx + 1) % GRID;
    ny = (cy + 1) % GRID;
    gx = SPAN - fx;
    gy = SPAN - fy;
    acc = gx * gy * noise_grid[PIX_W'(cx*GRID + cy)]
        + gx * fy * noise_grid[PIX_W'(cx*GRID + ny)]
        + fx * gy * noise_grid[PIX_W'(nx*GRID + cy)]
        + fx * fy * noise_grid[PIX_W'(nx*GRID + ny)];
    return acc / (SPAN * SPAN);
  endfunction

  function automatic pixel_res_t fractal_pixel(input logic [PIX_W-1:0] x,
                                               input logic [PIX_W-1:0] y);
    int unsigned total, k, shade, hi8, lo8, mixed;
    pixel_res_t r;
    total = 0;
    for (int oct = 0; oct < OCT_COUNT; oct++) begin
      k = 1 << oct;
      total += bilerp((k * x) % COORD_RANGE, (k * y) % COORD_RANGE) / k;
    end
    shade = total / 2;
    if (shade > FULL_WEIGHT) begin
      shade = FULL_WEIGHT;
    end
    r.intensity = shade[PIX_W-1:0];
    for (int ch = 0; ch < CHANNELS; ch++) begin
      hi8 = 32'((hue_hi >> (8 * ch)) & 24'hff);
      lo8 = 32'((hue_lo >> (8 * ch)) & 24'hff);
      mixed = (lo8 * (FULL_WEIGHT - shade) + hi8 * shade) / FULL_WEIGHT;
      r.color[8*ch +: 8] = mixed[7:0];
    end
    return r;
  endfunction

  // Result side: random ready bursts, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_left = LONG_HOLD;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_ch.ready = 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d pixels outstanding", $time, pending_pixels.size());
      $display("RESULT: ERROR");
      $finish;
    end else if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual intensity %0d color %06h",
                 $time, out_ch.intensity, out_ch.pixel_color);
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (out_ch.intensity !== want.intensity) begin
          errors++;
          $display("%0t: intensity mismatch, expected %0d, actual %0d",
                   $time, want.intensity, out_ch.intensity);
        end
        if (out_ch.pixel_color !== want.color) begin
          errors++;
          $display("%0t: pixel_color mismatch, expected %06h, actual %06h",
                   $time, want.color, out_ch.pixel_color);
        end
      end
    end
  end

  // Offers one item from a falling edge and returns after its transfer.
  task automatic send_item(input cmd_t c, input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                           input logic [PIX_W-1:0] idx, input logic [PIX_W-1:0] val);
    bit done;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.cmd         = c;
    in_ch.x_coord     = x;
    in_ch.y_coord     = y;
    in_ch.table_index = idx;
    in_ch.table_value = val;
    in_ch.valid       = 1'b1;
    done = 1'b0;
    while (!done) begin
      @(posedge clk);
      done = in_ch.ready;
    end
    if (c == CMD_LOAD) begin
      noise_grid[idx] = val;
      loads_done++;
    end else begin
      pending_pixels.push_back(fractal_pixel(x, y));
    end
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
    send_item(CMD_PIXEL, x, y, PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)));
  endtask

  task automatic send_load(input logic [PIX_W-1:0] idx, input logic [PIX_W-1:0] val);
    send_item(CMD_LOAD, PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)), idx,
              val);
  endtask

  task automatic fill_grid(input bit rand_fill, input logic [PIX_W-1:0] level);
    for (int i = 0; i < GRID * GRID; i++) begin
      send_load(PIX_W'(i), rand_fill ? PIX_W'($urandom_range(0, 255)) : level);
    end
  endtask

  // Waits until every pixel result is back, then lets trailing loads finish.
  task automatic settle;
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_colors(input logic [COLOR_W-1:0] hi, input logic [COLOR_W-1:0] lo);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = CFG_COLOR_HIGH;
    cfg_wdata = hi;
    @(negedge clk);
    cfg_index = CFG_COLOR_LOW;
    cfg_wdata = lo;
    @(negedge clk);
    cfg_we = 1'b0;
    hue_hi = hi;
    hue_lo = lo;
    cfg_writes += 2;
  endtask

  // Mostly pixels, with table entries rewritten now and then.
  task automatic random_items(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        send_load(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)));
      end else begin
        send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic color_phase(input logic [COLOR_W-1:0] hi, input logic [COLOR_W-1:0] lo,
                             input int count);
    settle();
    set_colors(hi, lo);
    random_items(count);
  endtask

  // An all-zero table gives black; an all-255 table gives the largest intensity.
  task automatic test_flat_grid;
    fill_grid(1'b0, 8'h00);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    fill_grid(1'b0, 8'hff);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd137, 8'd58);
    settle();
  endtask

  task automatic test_grid_corners;
    fill_grid(1'b1, 8'h00);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd0, 8'd255);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd15, 8'd15);
    send_pixel(8'd16, 8'd16);
    send_pixel(8'd240, 8'd241);
    send_pixel(8'd170, 8'd85);
    send_pixel(8'd85, 8'd170);
    send_pixel(8'd1, 8'd254);
    // A load followed by a pixel that reads the new entry.
    send_load(8'd0, 8'hff);
    send_pixel(8'd0, 8'd0);
    // The last cell wraps around to the first row and column.
    send_load(8'd255, 8'h00);
    send_pixel(8'd250, 8'd250);
    settle();
  endtask

  task automatic test_color_extremes;
    color_phase(24'h000000, 24'hffffff, 20);
    color_phase(24'hffffff, 24'hffffff, 20);
    color_phase(24'h000000, 24'h000000, 20);
    color_phase(24'hff00ff, 24'h00ff00, 20);
    color_phase(COLOR_HIGH_RST, COLOR_LOW_RST, 20);
    settle();
  endtask

  // The receiver holds off while the sender keeps offering pixels back to back.
  task automatic test_backpressure;
    quiet = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++) begin
      send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)));
    end
    settle();
    quiet = 1'b0;
  endtask

  task automatic test_random_stream;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) begin
        quiet = 1'b1;
      end
      color_phase(COLOR_W'($urandom_range(0, 24'hffffff)),
                  COLOR_W'($urandom_range(0, 24'hffffff)), 67);
    end
    settle();
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_LOAD;
    in_ch.x_coord     = '0;
    in_ch.y_coord     = '0;
    in_ch.table_index = '0;
    in_ch.table_value = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_flat_grid();
    test_grid_corners();
    test_color_extremes();
    test_backpressure();
    test_random_stream();

    $display("Checked %0d pixels after %0d table loads and %0d color register writes.",
             pixels_checked, loads_done, cfg_writes);
    $display("Flat and random tables, coordinate and color extremes, and a long stall ran.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/fvn_pkg.sv
hw/rtl/fvn_if.sv
hw/rtl/fvn_lane.sv
hw/rtl/fractal_value_noise_color_blend.sv
test/tb.sv
